// ===== hw/rtl/balance_state_feedback_controller_macros.svh =====
// Assertion macros shared by the balance controller RTL.
`ifndef BALANCE_STATE_FEEDBACK_CONTROLLER_MACROS_SVH
`define BALANCE_STATE_FEEDBACK_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define BSFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define BSFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BSFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BSFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/bsfc_pkg.sv =====
// Package: commands, register indexes, reset values and shared types.
`default_nettype none
package bsfc_pkg;
	localparam logic [1:0] CMD_SPEED = 2'd0;
	localparam logic [1:0] CMD_TILT  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [2:0] REG_GAIN_SPEED     = 3'd0;
	localparam logic [2:0] REG_GAIN_TILT      = 3'd1;
	localparam logic [2:0] REG_GAIN_RATE      = 3'd2;
	localparam logic [2:0] REG_GAIN_INTEGRAL  = 3'd3;
	localparam logic [2:0] REG_FILTER_B       = 3'd4;
	localparam logic [2:0] REG_TILT_LIMIT     = 3'd5;
	localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd6;
	localparam logic [2:0] REG_SPEED_REF      = 3'd7;

	localparam logic [14:0] TILT_LIMIT_RST     = 15'd572;
	localparam logic [22:0] INTEGRAL_LIMIT_RST = 23'd409600;

	typedef struct packed {
		logic signed [31:0] speed;
		logic signed [31:0] tilt;
		logic signed [31:0] rate;
		logic signed [31:0] integral;
	} gains_t;

	// One control tick handed to the feedback pipeline.
	typedef struct packed {
		logic               trip;
		logic signed [16:0] err;
		logic signed [15:0] tilt;
		logic signed [15:0] rate;
		logic signed [23:0] integ;
	} fb_op_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bsfc_speed_filter.sv =====
// First-order low-pass update of the filtered speed, rounded and saturated.
`default_nettype none
module bsfc_speed_filter (
	input  wire logic        [15:0] coef_b,
	input  wire logic signed [15:0] sample,
	input  wire logic signed [15:0] prev_sample,
	input  wire logic signed [15:0] filtered,
	output logic signed [15:0]      filtered_next
);
	logic signed [16:0] in_sum;
	logic signed [17:0] fb_coef;
	logic signed [33:0] prod_in;
	logic signed [33:0] prod_fb;
	logic signed [35:0] acc;
	logic        [35:0] mag;
	logic        [35:0] rnd;
	logic        [19:0] quo;
	logic        [19:0] quo_neg;

	assign in_sum  = 17'(sample) + 17'(prev_sample);
	assign fb_coef = $signed(18'h10000) - $signed({1'b0, coef_b, 1'b0});
	assign prod_in = $signed({1'b0, coef_b}) * in_sum;
	assign prod_fb = fb_coef * filtered;
	assign acc     = 36'(prod_in) + 36'(prod_fb);
	assign mag     = acc[35] ? 36'd0 - acc : acc;
	assign rnd     = mag + 36'h8000;
	assign quo     = rnd[35:16];
	assign quo_neg = 20'd0 - quo;

	// round half away from zero, then saturate to 16 bits
	always_comb begin
		if (!acc[35]) begin
			filtered_next = (quo > 20'd32767) ? 16'sh7fff : $signed(quo[15:0]);
		end else begin
			filtered_next = (quo > 20'd32768) ? 16'sh8000 : $signed(quo_neg[15:0]);
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bsfc_feedback.sv =====
// Pipelined four-term state feedback: products, pair sums, round and saturate.
`default_nettype none
module bsfc_feedback #(
	parameter int PWM_MAX = 885
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bsfc_pkg::gains_t gains,
	input  wire logic            op_valid,
	output logic                 op_ready,
	input  wire bsfc_pkg::fb_op_t op,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output logic signed [10:0]   pwm_value,
	output logic                 active
);
	bsfc_pkg::fb_op_t   op_s2;
	logic               v_s2, v_s3, v_s4;
	logic               trip_s3, trip_s4;
	logic signed [55:0] p_speed_s3, p_tilt_s3, p_rate_s3, p_integ_s3;
	logic signed [56:0] sum_a_s4, sum_b_s4;
	logic               rdy_o, rdy_s4, rdy_s3, rdy_s2;

	logic signed [48:0] m_speed;
	logic signed [47:0] m_tilt, m_rate;
	logic signed [55:0] m_integ;
	logic signed [57:0] total;
	logic        [57:0] mag;
	logic        [57:0] rnd;
	logic        [37:0] quo;
	logic        [10:0] pwm_next;

	// a stage advances when the next one is empty or moving
	assign rdy_o    = !res_valid || res_ready;
	assign rdy_s4   = !v_s4 || rdy_o;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign op_ready = rdy_s2;

	assign m_speed = $signed(gains.speed) * op_s2.err;
	assign m_tilt  = $signed(gains.tilt) * op_s2.tilt;
	assign m_rate  = $signed(gains.rate) * op_s2.rate;
	assign m_integ = $signed(gains.integral) * op_s2.integ;

	assign total = 58'(sum_a_s4) + 58'(sum_b_s4);
	assign mag   = total[57] ? 58'd0 - total : total;
	assign rnd   = mag + 58'h80000;
	assign quo   = rnd[57:20];

	// the drive is the negated sum: a positive sum gives a negative drive
	always_comb begin
		if (trip_s4) begin
			pwm_next = 11'd0;
		end else if (!total[57] && (total != 58'd0)) begin
			pwm_next = (quo > 38'(PWM_MAX)) ? 11'd0 - 11'(PWM_MAX) : 11'd0 - quo[10:0];
		end else begin
			pwm_next = (quo > 38'(PWM_MAX)) ? 11'(PWM_MAX) : quo[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= op_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_o) res_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && op_valid) op_s2 <= op;
		if (rdy_s3 && v_s2) begin
			trip_s3    <= op_s2.trip;
			p_speed_s3 <= 56'(m_speed);
			p_tilt_s3  <= 56'(m_tilt);
			p_rate_s3  <= 56'(m_rate);
			p_integ_s3 <= m_integ;
		end
		if (rdy_s4 && v_s3) begin
			trip_s4  <= trip_s3;
			sum_a_s4 <= 57'(p_speed_s3) + 57'(p_tilt_s3);
			sum_b_s4 <= 57'(p_rate_s3) + 57'(p_integ_s3);
		end
		if (rdy_o && v_s4) begin
			pwm_value <= $signed(pwm_next);
			active    <= !trip_s4;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/balance_state_feedback_controller.sv =====
// Top level of the two-wheel balance controller with integral action.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one transaction per command:
//   a speed sample updates the low-pass filtered speed, a tilt sample stores
//   angle and rate, a control tick runs the controller once both sensors
//   have been seen. Unknown commands and early ticks are dropped silently.
// - Output channel (out_valid/out_ready) carries pwm_value and active, one
//   transaction per tick that runs; active low means the tilt limit tripped.
// - Throughput: one input transaction per cycle unless a tick stalls in the
//   input register. Sensor and state updates happen in the cycle an item
//   leaves that register; the filter and integrator clamp are combinational.
// - Path: a tick's result is valid after it has passed the input register,
//   operand stage, products, pair sums and the output register.
// - Stall: when the receiver holds out_ready low, the result stays in the
//   output register and earlier stages keep filling; in_ready drops only
//   once the tick path is full. Samples and dropped commands retire at once
//   unless a blocked tick still holds the input register ahead of them.
// - Reset clears all state and loads register defaults; config writes via
//   cfg_write/cfg_index/cfg_data take effect on the next cycle.
`default_nettype none
`include "balance_state_feedback_controller_macros.svh"
module balance_state_feedback_controller #(
	parameter int PWM_MAX = 885
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [31:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic        [1:0]  command,
	input  wire logic signed [15:0] speed_sample,
	input  wire logic signed [15:0] tilt_angle,
	input  wire logic signed [15:0] tilt_rate,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [10:0]      pwm_value,
	output logic                    active
);
	// configuration registers
	bsfc_pkg::gains_t   gains_q;
	logic        [15:0] filter_b_q;
	logic        [14:0] tilt_limit_q;
	logic        [22:0] integral_limit_q;
	logic signed [15:0] speed_ref_q;

	// controller state
	logic signed [15:0] filtered_q, prev_speed_q, stored_tilt_q, stored_rate_q;
	logic signed [23:0] integrator_q;
	logic               tilt_seen_q, speed_seen_q;

	// input register
	logic               v_s1;
	logic        [1:0]  cmd_s1;
	logic signed [15:0] speed_s1, tilt_s1, rate_s1;

	logic               tick_run;
	logic               adv_s1;
	logic               fb_ready;
	logic signed [15:0] filt_next;
	logic signed [16:0] err;
	logic        [16:0] tilt_mag;
	logic               trip;
	logic signed [24:0] integ_sum;
	logic signed [24:0] integ_lim;
	logic signed [23:0] integ_next;
	bsfc_pkg::fb_op_t   fb_op;

	// a tick runs only after both sensors have reported
	assign tick_run = v_s1 && (cmd_s1 == bsfc_pkg::CMD_TICK) && tilt_seen_q && speed_seen_q;
	// retire the held item: ticks wait for the feedback pipe, all else leaves at once
	assign adv_s1   = v_s1 && (!tick_run || fb_ready);
	assign in_ready = !v_s1 || adv_s1;

	bsfc_speed_filter u_filter (
		.coef_b       (filter_b_q),
		.sample       (speed_s1),
		.prev_sample  (prev_speed_q),
		.filtered     (filtered_q),
		.filtered_next(filt_next)
	);

	// speed error, tilt trip and clamped integrator for the tick in hand
	assign err       = 17'(filtered_q) - 17'(speed_ref_q);
	assign tilt_mag  = stored_tilt_q[15] ? 17'd0 - 17'(stored_tilt_q) : 17'(stored_tilt_q);
	assign trip      = tilt_mag > {2'b00, tilt_limit_q};
	assign integ_sum = 25'(integrator_q) + 25'(err);
	assign integ_lim = $signed({2'b00, integral_limit_q});

	always_comb begin
		if (integ_sum > integ_lim) begin
			integ_next = integ_lim[23:0];
		end else if (integ_sum < -integ_lim) begin
			integ_next = 24'd0 - integ_lim[23:0];
		end else begin
			integ_next = integ_sum[23:0];
		end
	end

	always_comb begin
		fb_op.trip  = trip;
		fb_op.err   = err;
		fb_op.tilt  = stored_tilt_q;
		fb_op.rate  = stored_rate_q;
		fb_op.integ = integ_next;
	end

	bsfc_feedback #(
		.PWM_MAX(PWM_MAX)
	) u_feedback (
		.clk      (clk),
		.arst_n   (arst_n),
		.gains    (gains_q),
		.op_valid (tick_run),
		.op_ready (fb_ready),
		.op       (fb_op),
		.res_valid(out_valid),
		.res_ready(out_ready),
		.pwm_value(pwm_value),
		.active   (active)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q          <= '0;
			filter_b_q       <= '0;
			tilt_limit_q     <= bsfc_pkg::TILT_LIMIT_RST;
			integral_limit_q <= bsfc_pkg::INTEGRAL_LIMIT_RST;
			speed_ref_q      <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				bsfc_pkg::REG_GAIN_SPEED:     gains_q.speed    <= $signed(cfg_data);
				bsfc_pkg::REG_GAIN_TILT:      gains_q.tilt     <= $signed(cfg_data);
				bsfc_pkg::REG_GAIN_RATE:      gains_q.rate     <= $signed(cfg_data);
				bsfc_pkg::REG_GAIN_INTEGRAL:  gains_q.integral <= $signed(cfg_data);
				bsfc_pkg::REG_FILTER_B:       filter_b_q       <= cfg_data[15:0];
				bsfc_pkg::REG_TILT_LIMIT:     tilt_limit_q     <= cfg_data[14:0];
				bsfc_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[22:0];
				bsfc_pkg::REG_SPEED_REF:      speed_ref_q      <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1   <= command;
			speed_s1 <= speed_sample;
			tilt_s1  <= tilt_angle;
			rate_s1  <= tilt_rate;
		end
	end

	// state update as the held item retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_q    <= '0;
			prev_speed_q  <= '0;
			stored_tilt_q <= '0;
			stored_rate_q <= '0;
			integrator_q  <= '0;
			tilt_seen_q   <= 1'b0;
			speed_seen_q  <= 1'b0;
		end else if (adv_s1) begin
			case (cmd_s1)
				bsfc_pkg::CMD_SPEED: begin
					filtered_q   <= filt_next;
					prev_speed_q <= speed_s1;
					speed_seen_q <= 1'b1;
				end
				bsfc_pkg::CMD_TILT: begin
					stored_tilt_q <= tilt_s1;
					stored_rate_q <= rate_s1;
					tilt_seen_q   <= 1'b1;
				end
				bsfc_pkg::CMD_TICK: begin
					if (tick_run) begin
						integrator_q <= trip ? 24'sd0 : integ_next;
					end
				end
				default: ;
			endcase
		end
	end

	`BSFC_ASSERT_IMP(a_trip_zero_drive, clk, arst_n, out_valid && !active, pwm_value == 11'sd0, "tripped result with nonzero drive")
	`BSFC_ASSERT_IMP(a_drive_range, clk, arst_n, out_valid, ($signed(pwm_value) <= $signed(11'(PWM_MAX))) && ($signed(pwm_value) >= -$signed(11'(PWM_MAX))), "drive outside limit")
	`BSFC_ASSERT_NXT(a_trip_clears_integ, clk, arst_n, adv_s1 && tick_run && trip, integrator_q == 24'sd0, "integrator not cleared on trip")
	`BSFC_ASSERT_NXT(a_tilt_keeps_filter, clk, arst_n, adv_s1 && (cmd_s1 == bsfc_pkg::CMD_TILT), $stable(filtered_q), "tilt sample moved filtered speed")
endmodule
`default_nettype wire

// ===== tb/bsfc_checker.sv =====
// Checker for the balance controller: predicts each tick's drive value and compares it.
`default_nettype none
module bsfc_checker #(
	parameter int PWM_MAX = 885
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [31:0] cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic        [1:0]  command,
	input  wire logic signed [15:0] speed_sample,
	input  wire logic signed [15:0] tilt_angle,
	input  wire logic signed [15:0] tilt_rate,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [10:0] pwm_value,
	input  wire logic               active,
	input  wire logic               drain_check,
	output int                      mismatches,
	output int                      awaiting,
	output int                      results_seen,
	output int                      trips_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [10:0] pwm;
		logic               active;
	} drive_t;

	bsfc_pkg::gains_t   gains;
	logic        [15:0] filter_b;
	logic        [14:0] tilt_limit;
	logic        [22:0] integral_limit;
	logic signed [15:0] speed_ref;

	logic signed [15:0] speed_lp;
	logic signed [15:0] speed_prev;
	logic signed [15:0] tilt_held;
	logic signed [15:0] rate_held;
	logic signed [23:0] integ;
	logic               have_tilt;
	logic               have_speed;

	drive_t drive_q[$];

	// Round v / 2^sh to nearest, halves away from zero.
	function automatic longint round_away(longint v, int unsigned sh);
		longint unsigned m;
		if (v < 0)
			m = -v;
		else
			m = v;
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("bsfc_checker: mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		longint acc;
		longint err;
		longint sum;
		longint mag;
		longint pwm;
		drive_t want;
		if (!arst_n) begin
			gains = '0;
			filter_b = '0;
			tilt_limit = bsfc_pkg::TILT_LIMIT_RST;
			integral_limit = bsfc_pkg::INTEGRAL_LIMIT_RST;
			speed_ref = '0;
			speed_lp = '0;
			speed_prev = '0;
			tilt_held = '0;
			rate_held = '0;
			integ = '0;
			have_tilt = 1'b0;
			have_speed = 1'b0;
			drive_q.delete();
			awaiting = 0;
			mismatches = 0;
			results_seen = 0;
			trips_seen = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					bsfc_pkg::REG_GAIN_SPEED:     gains.speed = cfg_data;
					bsfc_pkg::REG_GAIN_TILT:      gains.tilt = cfg_data;
					bsfc_pkg::REG_GAIN_RATE:      gains.rate = cfg_data;
					bsfc_pkg::REG_GAIN_INTEGRAL:  gains.integral = cfg_data;
					bsfc_pkg::REG_FILTER_B:       filter_b = cfg_data[15:0];
					bsfc_pkg::REG_TILT_LIMIT:     tilt_limit = cfg_data[14:0];
					bsfc_pkg::REG_INTEGRAL_LIMIT: integral_limit = cfg_data[22:0];
					bsfc_pkg::REG_SPEED_REF:      speed_ref = cfg_data[15:0];
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				results_seen++;
				if (drive_q.size() == 0) begin
					report_mismatch($sformatf("result pwm=%0d active=%0b with nothing expected",
						pwm_value, active));
				end else begin
					want = drive_q.pop_front();
					if (pwm_value !== want.pwm)
						report_mismatch($sformatf("pwm_value %0d, expected %0d",
							pwm_value, want.pwm));
					if (active !== want.active)
						report_mismatch($sformatf("active %0b, expected %0b",
							active, want.active));
				end
			end

			if (in_valid && in_ready) begin
				case (command)
					bsfc_pkg::CMD_SPEED: begin
						acc = longint'(filter_b) * (longint'(speed_sample) + longint'(speed_prev))
							+ (64'sd65536 - 2 * longint'(filter_b)) * longint'(speed_lp);
						speed_lp = 16'(clip(round_away(acc, 16), -32768, 32767));
						speed_prev = speed_sample;
						have_speed = 1'b1;
					end
					bsfc_pkg::CMD_TILT: begin
						tilt_held = tilt_angle;
						rate_held = tilt_rate;
						have_tilt = 1'b1;
					end
					bsfc_pkg::CMD_TICK: begin
						if (have_tilt && have_speed) begin
							mag = (tilt_held < 0) ? -longint'(tilt_held) : longint'(tilt_held);
							if (mag > longint'(tilt_limit)) begin
								integ = '0;
								want.pwm = '0;
								want.active = 1'b0;
								trips_seen++;
							end else begin
								err = longint'(speed_lp) - longint'(speed_ref);
								integ = 24'(clip(longint'(integ) + err,
									-longint'(integral_limit), longint'(integral_limit)));
								sum = longint'(gains.speed) * err
									+ longint'(gains.tilt) * longint'(tilt_held)
									+ longint'(gains.rate) * longint'(rate_held)
									+ longint'(gains.integral) * longint'(integ);
								pwm = clip(round_away(-sum, 20), -PWM_MAX, PWM_MAX);
								want.pwm = 11'(pwm);
								want.active = 1'b1;
							end
							drive_q.insert(drive_q.size(), want);
						end
					end
					default: ;
				endcase
			end

			if (drain_check && drive_q.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", drive_q.size()));
			awaiting = drive_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top for the balance controller: stimulus, handshake pacing and verdict.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PWM_MAX = 885;
	// Tick result delay, used to size the pause in wait_drained.
	localparam int LATENCY = 4;
	// Cycles without any transaction before the run is declared hung.
	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 320;
	// The block drops this command silently.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum {
		SET_MODERATE,
		SET_MAX,
		SET_MIN,
		SET_HALF_B,
		SET_RANDOM
	} setting_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic        [2:0]  cfg_index;
	logic        [31:0] cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic        [1:0]  command;
	logic signed [15:0] speed_sample;
	logic signed [15:0] tilt_angle;
	logic signed [15:0] tilt_rate;
	logic               out_valid;
	logic               out_ready;
	logic signed [10:0] pwm_value;
	logic               active;
	logic               drain_check;

	int mismatches;
	int awaiting;
	int results_seen;
	int trips_seen;

	// Suppress random gaps on both channels while set.
	logic        steady;
	int          sent;
	int          settings_used;
	int          stall_cycles;
	logic [14:0] cur_tilt_limit;
	setting_t    plan [6] = '{SET_RANDOM, SET_MAX, SET_MODERATE, SET_HALF_B, SET_MIN, SET_RANDOM};

	balance_state_feedback_controller #(.PWM_MAX(PWM_MAX)) dut (
		.clk,
		.arst_n,
		.cfg_write,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_ready,
		.command,
		.speed_sample,
		.tilt_angle,
		.tilt_rate,
		.out_valid,
		.out_ready,
		.pwm_value,
		.active
	);

	bsfc_checker #(.PWM_MAX(PWM_MAX)) watch (
		.clk,
		.arst_n,
		.cfg_write,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_ready,
		.command,
		.speed_sample,
		.tilt_angle,
		.tilt_rate,
		.out_valid,
		.out_ready,
		.pwm_value,
		.active,
		.drain_check,
		.mismatches,
		.awaiting,
		.results_seen,
		.trips_seen
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: drop out_ready at random about 31 percent of the time, never while steady.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= steady || ($urandom_range(99) >= 31);
		end
	end

	// Watchdog: end the run once no transaction has moved for too long.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb_top: no transaction for %0d cycles", STALL_LIMIT);
		$display("tb_top: done, errors");
		$finish;
	end

	// Present one input transaction and hold it until accepted. Entered and
	// left between edges; the next call decides at the next falling edge
	// whether valid drops for a gap or carries a fresh payload.
	task automatic send(input logic [1:0] cmd, input logic signed [15:0] spd,
		input logic signed [15:0] ang, input logic signed [15:0] rate);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		speed_sample <= spd;
		tilt_angle <= ang;
		tilt_rate <= rate;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
	endtask

	// Hold the sender until every expected result has been taken, then give
	// the pipeline time to retire samples and dropped ticks too.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (2 * LATENCY) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Gains spread over many magnitudes: most land where the drive value
	// is not simply pinned at the rail.
	function automatic logic signed [31:0] rand_gain();
		logic signed [31:0] g;
		g = $urandom;
		return g >>> $urandom_range(6, 31);
	endfunction

	// Write every register for one phase. Call only with the block idle.
	task automatic load_setting(input setting_t kind);
		logic signed [31:0] gs;
		logic signed [31:0] gt;
		logic signed [31:0] gr;
		logic signed [31:0] gi;
		logic        [15:0] fb;
		logic        [14:0] tl;
		logic        [22:0] il;
		logic signed [15:0] sr;
		gs = rand_gain();
		gt = rand_gain();
		gr = rand_gain();
		gi = rand_gain();
		fb = 16'($urandom);
		tl = 15'($urandom_range(0, 8192));
		il = 23'($urandom_range(0, 8388607));
		sr = 16'($urandom);
		case (kind)
			SET_MODERATE: begin
				gs = 32'sd60000;
				gt = 32'sd900000;
				gr = 32'sd70000;
				gi = 32'sd300;
				fb = 16'd8192;
				tl = 15'd2048;
				il = bsfc_pkg::INTEGRAL_LIMIT_RST;
				sr = 16'sd410;
			end
			SET_MAX: begin
				gs = 32'sh7fffffff;
				gt = 32'sh7fffffff;
				gr = 32'sh7fffffff;
				gi = 32'sh7fffffff;
				fb = 16'hffff;
				tl = 15'h7fff;
				il = 23'h7fffff;
				sr = 16'sh7fff;
			end
			SET_MIN: begin
				// Zero limits: any nonzero tilt trips, the integrator stays pinned at zero.
				gs = 32'sh80000000;
				gt = 32'sh80000000;
				gr = 32'sh80000000;
				gi = 32'sh80000000;
				fb = 16'h0000;
				tl = 15'd0;
				il = 23'd0;
				sr = 16'sh8000;
			end
			// b of one half: the feedback term vanishes.
			SET_HALF_B: fb = 16'h8000;
			default: ;
		endcase
		write_reg(bsfc_pkg::REG_GAIN_SPEED, gs);
		write_reg(bsfc_pkg::REG_GAIN_TILT, gt);
		write_reg(bsfc_pkg::REG_GAIN_RATE, gr);
		write_reg(bsfc_pkg::REG_GAIN_INTEGRAL, gi);
		write_reg(bsfc_pkg::REG_FILTER_B, 32'(fb));
		write_reg(bsfc_pkg::REG_TILT_LIMIT, 32'(tl));
		write_reg(bsfc_pkg::REG_INTEGRAL_LIMIT, 32'(il));
		write_reg(bsfc_pkg::REG_SPEED_REF, 32'(sr));
		cur_tilt_limit = tl;
		settings_used++;
	endtask

	// Tilt angles clustered around the trip threshold, plus the full range.
	function automatic logic signed [15:0] pick_tilt();
		int mag;
		case ($urandom_range(2))
			0: mag = $urandom_range(0, int'(cur_tilt_limit));
			1: mag = int'(cur_tilt_limit) + $urandom_range(0, 2) - 1;
			default: return 16'($urandom);
		endcase
		return 16'($urandom_range(1) ? -mag : mag);
	endfunction

	task automatic send_random();
		int unsigned pick;
		logic signed [15:0] spd;
		pick = $urandom_range(99);
		// Half the speed samples stay near zero so the filter settles there.
		if ($urandom_range(1))
			spd = 16'($urandom);
		else
			spd = 16'($urandom_range(0, 2048)) - 16'sd1024;
		if (pick < 5)
			send(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
		else if (pick < 40)
			send(bsfc_pkg::CMD_SPEED, spd, 16'($urandom), 16'($urandom));
		else if (pick < 70)
			send(bsfc_pkg::CMD_TILT, 16'($urandom), pick_tilt(), 16'($urandom));
		else
			send(bsfc_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = bsfc_pkg::CMD_SPEED;
		speed_sample = '0;
		tilt_angle = '0;
		tilt_rate = '0;
		drain_check = 1'b0;
		steady = 1'b0;
		sent = 0;
		settings_used = 0;
		cur_tilt_limit = bsfc_pkg::TILT_LIMIT_RST;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed, at reset register values. Ticks before both sensors and
		// the unused command give nothing.
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);
		send(CMD_UNUSED, 16'sh7fff, -16'sd1, 16'sh5a5a);
		send(bsfc_pkg::CMD_SPEED, 16'sh7fff, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_TILT, 16'sd0, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);
		// Most negative angle trips (its magnitude counts as 32768).
		send(bsfc_pkg::CMD_TILT, 16'sd0, 16'sh8000, 16'sh7fff);
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);
		// Exactly at the limit still runs, one past it trips.
		send(bsfc_pkg::CMD_TILT, 16'sd0, 16'sd572, 16'sh8000);
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_TILT, 16'sd0, -16'sd573, 16'sd0);
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);

		wait_drained();
		load_setting(SET_MODERATE);
		send(bsfc_pkg::CMD_SPEED, 16'sh7fff, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_SPEED, 16'sh7fff, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_TILT, 16'sd0, 16'sd100, 16'sh8000);
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_SPEED, 16'sh8000, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_TILT, 16'sd0, -16'sd100, 16'sh7fff);
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);
		send(bsfc_pkg::CMD_TICK, 16'sd0, 16'sd0, 16'sd0);

		// Random phases, each under its own register setting.
		foreach (plan[p]) begin
			wait_drained();
			load_setting(plan[p]);
			steady = (p == 2);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == 2 && i == 250)
					steady = 1'b0;
				// Let the output side run dry once mid-phase.
				if (p == 3 && i == 160)
					wait_drained();
				send_random();
			end
		end
		steady = 1'b0;

		wait_drained();
		@(negedge clk);
		drain_check <= 1'b1;
		@(negedge clk);
		drain_check <= 1'b0;
		@(negedge clk);

		$display("tb_top: %0d input transactions under %0d register settings",
			sent, settings_used);
		$display("tb_top: %0d results compared, %0d of them tilt trips",
			results_seen, trips_seen);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bsfc_pkg.sv
hw/rtl/bsfc_speed_filter.sv
hw/rtl/bsfc_feedback.sv
hw/rtl/balance_state_feedback_controller.sv
tb/bsfc_checker.sv
tb/tb_top.sv
